### rtl/srsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker package
// Shared constants, status codes and the type of a queued item.
// ----------------------------------------------------------------------------
package srsc_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int ADDR_W          = 64;
  localparam int WINDOW_W        = 4;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 8;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd7;

  // Event kinds carried on the input tuser bit.
  localparam logic MODE_CALL   = 1'b0;
  localparam logic MODE_RETURN = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PUSHED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOFRAME = 2'd3;

  // One classified event waiting between the front end and the stack engine.
  typedef struct packed {
    logic              is_ret;
    logic [ADDR_W-1:0] addr;
  } q_item_t;

endpackage

### rtl/shadow_return_stack_checker.sv
`timescale 1ns / 1ps
// Results: a call's result is registered as the engine takes the item;
//   a return's once its search ends and the result register is free.
// Throughput: one call per cycle while results are taken; a return keeps
//   the stack engine busy for its whole search, whose pace is set by the
//   single read port of the stack memory and its registered read data.
// Reset: rst_n is synchronous and active low; it empties the stack and the
//   queue and sets the return window to 7. Stack contents are not cleared.
// ----------------------------------------------------------------------------
// Shadow return stack checker
// Tracks call addresses on a bounded stack and checks each return target
// against the stored frames.
// ----------------------------------------------------------------------------
module shadow_return_stack_checker #(
  parameter int STACK_DEPTH = srsc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input events.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] address
  input  logic [0:0]  in_tuser,   // [0] mode: 0 call, 1 return
  // Results, one per event.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frames_skipped, [15:8] depth_after
  output logic [1:0]  out_tuser,  // [1:0] status
  // Return window register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_wdata   // [3:0] return_window
);

  // The front end takes items into a short queue so that input acceptance
  // carries on while the engine walks the stack on a long return search.
  logic              q_valid;
  logic              q_ready;
  srsc_pkg::q_item_t q_item;

  logic [7:0] skipped;
  logic [7:0] depth_after;

  srsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser[0]),
    .in_addr  (in_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // The engine owns the stack memory, the depth count and the result
  // register. A call pushes and registers its result as it is taken; a
  // return first reads the top frame and then compares one frame per cycle,
  // popping as it goes, until a frame matches or the stack runs dry.
  srsc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .cfg_valid   (cfg_valid),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_skipped (skipped),
    .out_depth   (depth_after)
  );

  // The window register can always be written.
  assign cfg_ready = 1'b1;
  assign out_tdata = {depth_after, skipped};

endmodule

### rtl/srsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker front end
// Accepts events, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module srsc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [srsc_pkg::ADDR_W-1:0]  in_addr,
  output logic                         q_valid,
  input  logic                         q_ready,
  output srsc_pkg::q_item_t            q_item
);

  srsc_pkg::q_item_t slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Classification is stored with the item so the engine decodes nothing.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r].is_ret <= (in_mode == srsc_pkg::MODE_RETURN);
      slot_r[wr_ptr_r].addr   <= in_addr;
    end
  end

endmodule

### rtl/srsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker engine
// Holds the call stack memory, runs pushes and return searches, and keeps
// the registered result.
// ----------------------------------------------------------------------------
module srsc_back #(
  parameter int STACK_DEPTH = srsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  srsc_pkg::q_item_t              q_item,
  input  logic                           cfg_valid,
  input  logic [srsc_pkg::WINDOW_W-1:0]  cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srsc_pkg::STATUS_W-1:0]  out_status,
  output logic [srsc_pkg::COUNT_W-1:0]   out_skipped,
  output logic [srsc_pkg::COUNT_W-1:0]   out_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] ONE  = DW'(1);
  localparam logic [DW-1:0] TWO  = DW'(2);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RET  = 1'b1;

  logic [srsc_pkg::ADDR_W-1:0] mem [STACK_DEPTH];

  logic                            state_r, state_nxt;
  logic [DW-1:0]                   depth_r, depth_nxt;
  logic [DW-1:0]                   skip_r, skip_nxt;
  logic [srsc_pkg::ADDR_W-1:0]     target_r, target_nxt;
  logic [srsc_pkg::ADDR_W-1:0]     rd_data_r;
  logic [srsc_pkg::WINDOW_W-1:0]   window_r, window_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [srsc_pkg::STATUS_W-1:0]   out_status_r;
  logic [srsc_pkg::COUNT_W-1:0]    out_skipped_r, out_depth_r;

  logic                            mem_we, rd_en, load, out_free, hit, done;
  logic [DW-1:0]                   rd_ptr;
  logic [srsc_pkg::ADDR_W-1:0]     distance;
  logic [srsc_pkg::STATUS_W-1:0]   res_status;
  logic [DW-1:0]                   res_skip, res_depth;
  logic [DW+7:0]                   skip_ext, depth_ext;

  assign out_free = !out_valid_r || out_ready;

  // The frame on top sits in rd_data_r; it matches when the return target
  // lies one to window bytes above it, with wrap-around.
  assign distance = target_r - rd_data_r;
  assign hit      = (distance != '0) &&
                    (distance <= srsc_pkg::ADDR_W'(window_r));
  assign done     = hit || (depth_r == ONE);

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    skip_nxt   = skip_r;
    target_nxt = target_r;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_ptr     = depth_r - ONE;
    load       = 1'b0;
    res_status = srsc_pkg::ST_PUSHED;
    res_skip   = '0;
    res_depth  = depth_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          if (!q_item.is_ret) begin
            load = 1'b1;
            if (depth_r != FULL) begin
              mem_we    = 1'b1;
              depth_nxt = depth_r + ONE;
              res_depth = depth_r + ONE;
            end else begin
              res_status = srsc_pkg::ST_DROPPED;
            end
          end else if (depth_r == '0) begin
            load       = 1'b1;
            res_status = srsc_pkg::ST_NOFRAME;
          end else begin
            rd_en      = 1'b1;
            target_nxt = q_item.addr;
            skip_nxt   = '0;
            state_nxt  = S_RET;
          end
        end
      end
      S_RET: begin
        if (!done) begin
          depth_nxt = depth_r - ONE;
          skip_nxt  = skip_r + ONE;
          rd_en     = 1'b1;
          rd_ptr    = depth_r - TWO;
        end else if (out_free) begin
          depth_nxt  = depth_r - ONE;
          load       = 1'b1;
          res_status = hit ? srsc_pkg::ST_MATCHED : srsc_pkg::ST_NOFRAME;
          res_skip   = hit ? skip_r : skip_r + ONE;
          res_depth  = depth_r - ONE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign window_nxt    = cfg_valid ? cfg_wdata : window_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign skip_ext      = {8'b0, res_skip};
  assign depth_ext     = {8'b0, res_depth};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      window_r    <= srsc_pkg::WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    skip_r   <= skip_nxt;
    target_r <= target_nxt;
    if (load) begin
      out_status_r  <= res_status;
      out_skipped_r <= skip_ext[7:0];
      out_depth_r   <= depth_ext[7:0];
    end
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth_r[AW-1:0]] <= q_item.addr;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_skipped = out_skipped_r;
  assign out_depth   = out_depth_r;

endmodule

### rtl/srsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker port checks
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module srsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Calls never skip frames.
  a_call_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == srsc_pkg::ST_PUSHED ||
                   out_tuser == srsc_pkg::ST_DROPPED) |-> out_tdata[7:0] == 8'd0)
    else $error("call result reports skipped frames");

  // A failed return always leaves the stack empty.
  a_noframe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == srsc_pkg::ST_NOFRAME |-> out_tdata[15:8] == 8'd0)
    else $error("failed return left frames on the stack");

  // No result is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind shadow_return_stack_checker srsc_checker u_srsc_checker (.*);

### verif/tb_shadow_return_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow return stack checker testbench
// Streams call and return events into the checker with random gaps on both
// sides and compares every result with a cycle-free model of the shadow
// stack. The return window is rewritten between phases, including zero and
// fifteen, and the stack is driven to full, overflowed and unwound.
// ----------------------------------------------------------------------------
module tb_shadow_return_stack_checker;

  localparam int          DEPTH          = srsc_pkg::STACK_DEPTH_DEF;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 40;
  localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [srsc_pkg::STATUS_W-1:0] status;
    logic [srsc_pkg::COUNT_W-1:0]  skipped;
    logic [srsc_pkg::COUNT_W-1:0]  depth;
  } verdict_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;  // [63:0] address
  logic [0:0]  in_tuser   = '0;  // [0] mode: 0 call, 1 return
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] frames_skipped, [15:8] depth_after
  logic [1:0]  out_tuser;        // [1:0] status
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_wdata  = '0;  // [3:0] return_window

  // Events waiting to be sent, and verdicts waiting for their result item.
  srsc_pkg::q_item_t event_q[$];
  verdict_t          verdicts[$];

  // Model of the shadow stack, updated as each item is accepted.
  logic [63:0] shadow_mem [DEPTH];
  int unsigned shadow_depth  = 0;
  logic [3:0]  shadow_window = srsc_pkg::WINDOW_RESET;

  // Rough view of the stack used only to aim returns at live frames.
  logic [63:0] gen_frames[$];
  int unsigned gen_window = 32'(srsc_pkg::WINDOW_RESET);
  logic [63:0] last_call  = '0;

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned hold_left    = 0;
  logic        calm         = 1'b0;
  int unsigned calm_left    = 100;

  shadow_return_stack_checker #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, with the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Works out the result of one event and advances the stack model.
  task automatic judge_event(input logic is_ret, input logic [63:0] addr);
    verdict_t    v;
    logic [63:0] distance;
    logic        found;
    int unsigned skipped;
    found   = 1'b0;
    skipped = 0;
    if (is_ret == srsc_pkg::MODE_CALL) begin
      if (shadow_depth < DEPTH) begin
        shadow_mem[shadow_depth] = addr;
        shadow_depth++;
        v.status = srsc_pkg::ST_PUSHED;
      end else begin
        v.status = srsc_pkg::ST_DROPPED;
      end
    end else begin
      while (shadow_depth > 0 && !found) begin
        shadow_depth--;
        // The distance wraps modulo 2^64, so a target just above zero can
        // still match a call near the top of the address space.
        distance = addr - shadow_mem[shadow_depth];
        if (distance >= 64'd1 && distance <= {60'd0, shadow_window}) found = 1'b1;
        else skipped++;
      end
      v.status = found ? srsc_pkg::ST_MATCHED : srsc_pkg::ST_NOFRAME;
    end
    v.skipped = skipped[srsc_pkg::COUNT_W-1:0];
    v.depth   = shadow_depth[srsc_pkg::COUNT_W-1:0];
    verdicts.push_back(v);
  endtask

  task automatic push_call(input logic [63:0] addr);
    srsc_pkg::q_item_t ev;
    ev.is_ret = srsc_pkg::MODE_CALL;
    ev.addr   = addr;
    event_q.push_back(ev);
    if (gen_frames.size() < DEPTH) gen_frames.push_back(addr);
    last_call = addr;
  endtask

  task automatic push_return(input logic [63:0] addr);
    srsc_pkg::q_item_t ev;
    ev.is_ret = srsc_pkg::MODE_RETURN;
    ev.addr   = addr;
    event_q.push_back(ev);
  endtask

  function automatic logic [63:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return {$urandom, $urandom};
    else if (r < 75) return {32'd0, $urandom_range(0, 31)};
    else if (r < 90) return ALL_ONES - $urandom_range(0, 31);
    else return last_call + $urandom_range(0, 24);
  endfunction

  // A return that lands inside the window of frame idx, unwinding that frame and the ones above it.
  task automatic return_to(input int unsigned idx);
    logic [63:0] dummy;
    push_return(gen_frames[idx] + $urandom_range(1, (gen_window == 0) ? 1 : gen_window));
    while (gen_frames.size() > idx) dummy = gen_frames.pop_back();
  endtask

  task automatic fill_stack(input int unsigned n);
    for (int i = 0; i < n; i++) push_call({$urandom, $urandom});
  endtask

  // Mostly well-formed call and return traffic, with some broken returns
  // that miss the window and some returns to arbitrary addresses.
  task automatic gen_mixed(input int unsigned n);
    int unsigned r, k, span, last;
    logic [63:0] top;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(0, 99);
      span = (gen_window == 0) ? 1 : gen_window;
      if (r < 45 || (gen_frames.size() == 0 && r < 85)) begin
        push_call(pick_addr());
      end else if (r < 85) begin
        last = gen_frames.size() - 1;
        k = $urandom_range(0, 99);
        if (k < 70) k = 0;
        else if (k < 90) k = $urandom_range(0, (last < 3) ? last : 3);
        else k = $urandom_range(0, last);
        return_to(last - k);
      end else if (r < 93) begin
        top = (gen_frames.size() > 0) ? gen_frames[gen_frames.size() - 1] : pick_addr();
        case ($urandom_range(0, 2))
          0: push_return(top);
          1: push_return(top + span + 1 + $urandom_range(0, 15));
          default: push_return(top - 1 - $urandom_range(0, 15));
        endcase
        gen_frames.delete();
      end else begin
        push_return({$urandom, $urandom});
        gen_frames.delete();
      end
    end
  endtask

  // Returns once every queued event has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk); while (event_q.size() != 0 || in_tvalid || verdicts.size() != 0);
  endtask

  task automatic write_window(input logic [3:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= w;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid  <= 1'b0;
    gen_window = 32'(w);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Alternates stretches without any idling and stretches with random gaps.
  always @(negedge clk) begin
    if (calm_left == 0) begin
      calm      <= !calm;
      calm_left <= calm ? $urandom_range(200, 600) : $urandom_range(30, 120);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk) begin : drive_events
    srsc_pkg::q_item_t next_ev;
    if (!rst_n) begin
      in_tvalid     <= 1'b0;
      shadow_depth  = 0;
      shadow_window = srsc_pkg::WINDOW_RESET;
      send_gap      = 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_window = cfg_wdata;
      if (in_tvalid && in_tready) judge_event(in_tuser[0], in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (event_q.size() > 0) begin
          next_ev = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_ev.addr;
          in_tuser  <= next_ev.is_ret;
          send_gap  = calm ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got status %0d skipped %0d depth %0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[15:8]);
        end else begin
          want = verdicts.pop_front();
          check_field("status", {6'd0, want.status}, {6'd0, out_tuser});
          check_field("frames_skipped", want.skipped, out_tdata[7:0]);
          check_field("depth_after", want.depth, out_tdata[15:8]);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events under the reset window of seven.
    push_return(64'h0000_0000_0000_1234);          // return on an empty stack
    push_call(64'h0);
    push_return(64'h7);                            // distance equal to the window
    push_call(64'h100);
    push_return(64'h100);                          // zero distance never matches
    push_call(ALL_ONES);
    push_return(64'h6);                            // match across the wrap
    push_call(64'h1000);
    push_call(64'hDEAD_BEEF_0000_0000);
    push_call(64'h8000_0000_0000_0000);
    push_return(64'h1001);                         // two frames skipped
    push_call(64'h2000);
    push_return(64'h2008);                         // one past the window
    push_call(ALL_ONES);
    push_return(64'h0);
    push_call(64'h5555_5555_5555_5555);
    push_call(64'hAAAA_AAAA_AAAA_AAAA);
    push_return(64'hAAAA_AAAA_AAAA_AAAD);
    push_return(64'h5555_5555_5555_5556);
    wait_drained();
    gen_frames.delete();

    write_window(4'd15);
    gen_mixed(180);
    wait_drained();

    write_window(4'd1);
    gen_mixed(120);
    wait_drained();

    // With a zero window nothing matches; a full stack unwinds completely.
    write_window(4'd0);
    fill_stack(130);
    push_return({$urandom, $urandom});
    gen_frames.delete();
    gen_mixed(15);
    wait_drained();

    // Overflow, unwind to the bottom frame, then refill and work deep.
    write_window(4'($urandom_range(2, 14)));
    fill_stack(135);
    return_to(0);
    fill_stack(128);
    gen_mixed(60);
    wait_drained();

    write_window(4'($urandom_range(1, 15)));
    gen_mixed(80);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
